// File: sv/mmpb_pkg.sv
// Shared types and constants for the minimax path bottleneck block.
// No dependencies; imported by the controller, the datapath and the top level.
package mmpb_pkg;

   localparam int IN_COORD_W = 10;   // width of a coordinate on the request port
   localparam int OUT_BSQ_W  = 21;   // width of the squared bottleneck on the response port
   localparam int STATUS_W   = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK_RD,
      ST_PICK_CAP,
      ST_SWEEP,
      ST_DRAIN,
      ST_RESULT
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // store accepted point (or flag overflow)
      logic start;        // first round: pick node 0 at bottleneck 0
      logic round_start;  // read pick coords, clear sweep index and running minimum
      logic pick_cap;     // capture pick coords from point RAM
      logic issue;        // issue one sweep address
      logic next_round;   // running minimum becomes the next pick
      logic emit;         // load response register, clear point set
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;   // no point stored yet
      logic sweep_last;   // sweep index is at the last stored point
      logic pipe_busy;    // relaxation pipeline holds work
      logic pick_is_one;  // running minimum sits on node 1
      logic out_free;     // response register can take a new transaction
   } dp_sts_type;

endpackage

// File: sv/minimax_path_bottleneck.sv
// Minimax path bottleneck: points load at one transaction per cycle while the controller is idle.
// The last transaction runs rounds of pick/sweep/drain over the n stored points; each round
// makes one relax/scan pass through the bottleneck RAM read port.
// Rounds end when node 1 is picked: at most n - 1 rounds.
// A last point with no earlier point goes straight to the result. Synchronous reset clears the
// point count, overflow flag, FSM and pipeline; RAM contents are not cleared.
module minimax_path_bottleneck #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mmpb_pkg::IN_COORD_W-1:0]     req_x_coord,
   input  logic [mmpb_pkg::IN_COORD_W-1:0]     req_y_coord,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mmpb_pkg::OUT_BSQ_W-1:0]      rsp_bottleneck_sq,
   output logic [mmpb_pkg::STATUS_W-1:0]       rsp_status
);
   import mmpb_pkg::*;

   // command/status between FSM and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // Controller: accepts points only while idle; one compute at a time.
   mmpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: point RAM, bottleneck/visited RAM, relax pipeline, response register.
   // The response register lets a new point set load while a result waits.
   mmpb_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bottleneck_sq (rsp_bottleneck_sq),
      .rsp_status        (rsp_status)
   );

endmodule

// File: sv/mmpb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mmpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mmpb_dp.sv
// Datapath: point store, bottleneck store, five-stage relax/scan pipeline, response register.
// Depends on mmpb_pkg and mmpb_ram.
module mmpb_dp #(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mmpb_pkg::dp_cmd_type                   cmd,
   output mmpb_pkg::dp_sts_type                   sts,
   input  logic [mmpb_pkg::IN_COORD_W-1:0]        req_x_coord,
   input  logic [mmpb_pkg::IN_COORD_W-1:0]        req_y_coord,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [mmpb_pkg::OUT_BSQ_W-1:0]         rsp_bottleneck_sq,
   output logic [mmpb_pkg::STATUS_W-1:0]          rsp_status
);
   import mmpb_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = COORD_BITS;
   localparam int DW = 2 * CW + 1;                       // squared distance
   localparam int XW = (CW > IN_COORD_W) ? CW : IN_COORD_W;
   localparam int VW = (DW > OUT_BSQ_W) ? DW : OUT_BSQ_W;

   localparam logic [DW-1:0] INF = {DW{1'b1}};          // never a real distance

   // point set bookkeeping
   logic [NW-1:0] count_ff;
   logic          overflow_ff;
   logic          full;

   // round state
   logic [AW-1:0] pick_ff;
   logic [DW-1:0] pick_best_ff;
   logic          first_ff;
   logic [CW-1:0] px_ff, py_ff;
   logic [AW-1:0] idx_ff;
   logic [NW-1:0] cnt_m1;

   // running minimum over unvisited nodes
   logic [DW-1:0] min_val_ff;
   logic [AW-1:0] min_idx_ff;
   logic          min_found_ff;

   // RAM ports
   logic [XW-1:0]     x_wide, y_wide;
   logic [2*CW-1:0]   pt_rd;
   logic [DW:0]       bst_rd;
   logic [AW-1:0]     pt_rd_addr;

   // pipeline
   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [AW-1:0] a1_ff, a2_ff, a3_ff, a4_ff, a5_ff;
   logic [CW-1:0] x1, y1, dx1, dy1;
   logic [DW-1:0] best1;
   logic          vis1;
   logic [CW-1:0] dx_ff, dy_ff;
   logic [DW-1:0] best2_ff, best3_ff, best4_ff;
   logic          vis2_ff, vis3_ff, vis4_ff;
   logic [2*CW-1:0] sqx_c, sqy_c, sqx_ff, sqy_ff;
   logic [DW-1:0] dsum_ff;
   logic          is_pick4;
   logic [DW-1:0] hop4, nbest4;
   logic          nvis4;
   logic [DW-1:0] nbest5_ff;
   logic          nvis5_ff;

   // response
   logic                 rsp_valid_ff;
   logic [OUT_BSQ_W-1:0] rsp_bsq_ff;
   status_type           rsp_status_ff;
   logic [VW-1:0]        min_wide;
   logic                 short_set;

   // ---------------- point store ----------------
   assign x_wide = XW'(req_x_coord);
   assign y_wide = XW'(req_y_coord);
   assign full   = (count_ff == NW'(MAX_POINTS));
   assign pt_rd_addr = cmd.round_start ? pick_ff : idx_ff;

   mmpb_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock   (clock),
      .wr_en   (cmd.load && !full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({x_wide[CW-1:0], y_wide[CW-1:0]}),
      .rd_en   (cmd.round_start || cmd.issue),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd)
   );

   // {visited, best bottleneck}; contents ignored during the first round
   mmpb_ram #(.WIDTH(DW + 1), .DEPTH(MAX_POINTS)) u_bst_ram (
      .clock   (clock),
      .wr_en   (v4_ff),
      .wr_addr (a4_ff),
      .wr_data ({nvis4, nbest4}),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (bst_rd)
   );

   // ---------------- stage 1: RAM data -> abs differences ----------------
   assign x1    = pt_rd[2*CW-1:CW];
   assign y1    = pt_rd[CW-1:0];
   assign best1 = first_ff ? INF : bst_rd[DW-1:0];
   assign vis1  = first_ff ? 1'b0 : bst_rd[DW];
   assign dx1   = (x1 >= px_ff) ? (x1 - px_ff) : (px_ff - x1);
   assign dy1   = (y1 >= py_ff) ? (y1 - py_ff) : (py_ff - y1);

   // ---------------- stage 2: squares ----------------
   assign sqx_c = dx_ff * dx_ff;
   assign sqy_c = dy_ff * dy_ff;

   // ---------------- stage 4: relax and write back ----------------
   assign is_pick4 = (a4_ff == pick_ff);
   assign hop4     = (dsum_ff > pick_best_ff) ? dsum_ff : pick_best_ff;
   assign nvis4    = vis4_ff || is_pick4;
   always_comb begin
      if (is_pick4) begin
         nbest4 = pick_best_ff;
      end else if (!vis4_ff && (hop4 < best4_ff)) begin
         nbest4 = hop4;
      end else begin
         nbest4 = best4_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= idx_ff;
      dx_ff    <= dx1;
      dy_ff    <= dy1;
      best2_ff <= best1;
      vis2_ff  <= vis1;
      a2_ff    <= a1_ff;
      sqx_ff   <= sqx_c;
      sqy_ff   <= sqy_c;
      best3_ff <= best2_ff;
      vis3_ff  <= vis2_ff;
      a3_ff    <= a2_ff;
      dsum_ff  <= DW'(sqx_ff) + DW'(sqy_ff);
      best4_ff <= best3_ff;
      vis4_ff  <= vis3_ff;
      a4_ff    <= a3_ff;
      nbest5_ff <= nbest4;
      nvis5_ff  <= nvis4;
      a5_ff     <= a4_ff;
      if (cmd.pick_cap) begin
         px_ff <= x1;
         py_ff <= y1;
      end
   end

   // ---------------- control registers ----------------
   assign cnt_m1 = count_ff - NW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         first_ff     <= 1'b0;
         pick_ff      <= '0;
         pick_best_ff <= '0;
         idx_ff       <= '0;
         min_found_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;

         if (cmd.load) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + NW'(1);
            end
         end

         if (cmd.start) begin
            first_ff     <= 1'b1;
            pick_ff      <= '0;
            pick_best_ff <= '0;
         end else if (cmd.next_round) begin
            first_ff     <= 1'b0;
            pick_ff      <= min_idx_ff;
            pick_best_ff <= min_val_ff;
         end

         if (cmd.round_start) begin
            idx_ff       <= '0;
            min_found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               idx_ff <= idx_ff + AW'(1);
            end
            // ascending addresses with strict compare: lowest index wins ties
            if (v5_ff && !nvis5_ff && (!min_found_ff || (nbest5_ff < min_val_ff))) begin
               min_found_ff <= 1'b1;
            end
         end

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= '0;
            overflow_ff  <= 1'b0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // running minimum payload
   always_ff @(posedge clock) begin
      if (!cmd.round_start && v5_ff && !nvis5_ff &&
          (!min_found_ff || (nbest5_ff < min_val_ff))) begin
         min_val_ff <= nbest5_ff;
         min_idx_ff <= a5_ff;
      end
   end

   // ---------------- response register ----------------
   assign min_wide  = VW'(min_val_ff);
   assign short_set = (count_ff < NW'(2));

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (short_set) begin
            rsp_bsq_ff    <= '0;
            rsp_status_ff <= STATUS_SHORT;
         end else begin
            rsp_bsq_ff    <= min_wide[OUT_BSQ_W-1:0];
            rsp_status_ff <= overflow_ff ? STATUS_OVERFLOW : STATUS_OK;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bottleneck_sq = rsp_bsq_ff;
   assign rsp_status        = rsp_status_ff;

   // ---------------- status ----------------
   assign sts.count_zero  = (count_ff == '0);
   assign sts.sweep_last  = (idx_ff == cnt_m1[AW-1:0]);
   assign sts.pipe_busy   = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
   assign sts.pick_is_one = (min_idx_ff == AW'(1));
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

`ifndef SYNTH
   // write-back never lands on the entry being read in the same cycle
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && cmd.issue) |-> (a4_ff != idx_ff))
      else $error("bottleneck RAM read/write collision");

   // minimax Dijkstra picks in non-decreasing bottleneck order
   a_pick_monotonic: assert property (@(posedge clock) disable iff (reset)
      cmd.next_round |-> (min_val_ff >= pick_best_ff))
      else $error("pick bottleneck decreased");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten before taken");
`endif

endmodule

// File: sv/mmpb_ctrl.sv
// Controller FSM: load, per-round pick/sweep/drain sequencing, response hand-off.
// Depends on mmpb_pkg.
module mmpb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  mmpb_pkg::dp_sts_type sts,
   output mmpb_pkg::dp_cmd_type cmd
);
   import mmpb_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  if (sts.count_zero) begin
                     state_in = ST_RESULT;
                  end else begin
                     cmd.start = 1'b1;
                     state_in  = ST_PICK_RD;
                  end
               end
            end
         end
         ST_PICK_RD: begin
            cmd.round_start = 1'b1;
            state_in        = ST_PICK_CAP;
         end
         ST_PICK_CAP: begin
            cmd.pick_cap = 1'b1;
            state_in     = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               if (sts.pick_is_one) begin
                  state_in = ST_RESULT;
               end else begin
                  cmd.next_round = 1'b1;
                  state_in       = ST_PICK_RD;
               end
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_round_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_PICK_RD) ##1 (state_ff == ST_PICK_CAP)
                    ##1 (state_ff == ST_SWEEP))
      else $error("round setup out of order");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("sweep left without drain");

   a_emit_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !req_stall)
      else $error("input not reopened after response");
`endif

endmodule

// File: bench/mmpb_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the minimax path bottleneck bench: point-set predictor and answer queue.
// Depends on mmpb_pkg for the port widths and the status codes.
package mmpb_tb_pkg;
   import mmpb_pkg::*;

   localparam int STORE_DEPTH  = 256;
   localparam int UNREACHED    = 32'h7FFF_FFFF;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [OUT_BSQ_W-1:0] bottleneck_sq;
      status_type           status;
   } answer_type;

   class bottleneck_scoreboard;
      logic [IN_COORD_W-1:0] xs [STORE_DEPTH];
      logic [IN_COORD_W-1:0] ys [STORE_DEPTH];
      int                    stored;
      bit                    dropped;
      answer_type            pending_answers [$];
      int                    failures;

      function new();
         stored   = 0;
         dropped  = 1'b0;
         failures = 0;
      endfunction

      // Dense minimax search from point 0; stops once point 1 is settled.
      function int minimax_sq();
         int best [STORE_DEPTH];
         bit settled [STORE_DEPTH];
         int pick, dx, dy, hop;
         for (int i = 0; i < stored; i++) begin
            best[i]    = UNREACHED;
            settled[i] = 1'b0;
         end
         best[0] = 0;
         for (int r = 0; r < stored; r++) begin
            pick = -1;
            for (int i = 0; i < stored; i++)
               if (!settled[i] && (pick < 0 || best[i] < best[pick]))
                  pick = i;
            if (pick < 0 || best[pick] == UNREACHED)
               break;
            settled[pick] = 1'b1;
            if (pick == 1)
               break;
            for (int i = 0; i < stored; i++) begin
               if (!settled[i]) begin
                  dx  = int'(xs[pick]) - int'(xs[i]);
                  dy  = int'(ys[pick]) - int'(ys[i]);
                  hop = dx * dx + dy * dy;
                  if (hop < best[pick])
                     hop = best[pick];
                  if (hop < best[i])
                     best[i] = hop;
               end
            end
         end
         return best[1];
      endfunction

      function void note_point(input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                               input logic last);
         answer_type ans;
         int         full;
         if (stored < STORE_DEPTH) begin
            xs[stored] = x;
            ys[stored] = y;
            stored++;
         end else begin
            dropped = 1'b1;
         end
         if (!last)
            return;
         if (stored < 2) begin
            ans.bottleneck_sq = '0;
            ans.status        = STATUS_SHORT;
         end else begin
            full              = minimax_sq();
            ans.bottleneck_sq = full[OUT_BSQ_W-1:0];
            ans.status        = dropped ? STATUS_OVERFLOW : STATUS_OK;
         end
         pending_answers.insert(pending_answers.size(), ans);
         stored  = 0;
         dropped = 1'b0;
      endfunction

      function void check_answer(input logic [OUT_BSQ_W-1:0] bsq, input logic [STATUS_W-1:0] st);
         answer_type exp;
         if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected answer bottleneck_sq=%0d status=%0d", $time, bsq, st);
            return;
         end
         exp = pending_answers.pop_front();
         if (bsq !== exp.bottleneck_sq || st !== exp.status) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: mismatch bottleneck_sq exp %0d got %0d, status exp %0d got %0d",
                        $time, exp.bottleneck_sq, bsq, exp.status, st);
         end
      endfunction
   endclass

endpackage

// File: bench/minimax_path_bottleneck_tb.sv
`timescale 1ns / 1ps
// Top-level bench for minimax_path_bottleneck: drives point sets, stalls the answer side.
// Depends on mmpb_pkg (RTL types) and mmpb_tb_pkg (scoreboard).
module minimax_path_bottleneck_tb;
   import mmpb_pkg::*;
   import mmpb_tb_pkg::*;

   localparam int TARGET_ITEMS = 1950;
   localparam int HOLD_CYCLES  = 3000;    // long answer-side hold-off, fills the block
   localparam int IDLE_LIMIT   = 250000;  // watchdog limit on quiet cycles, must cover a full 256-point set
   localparam int DRAIN_CYCLES = 64;

   typedef enum {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_CORNERS} spread_type;
   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [IN_COORD_W-1:0] req_x_coord;
   logic [IN_COORD_W-1:0] req_y_coord;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [OUT_BSQ_W-1:0]  rsp_bottleneck_sq;
   logic [STATUS_W-1:0]   rsp_status;

   bottleneck_scoreboard bottleneck_check;
   int                   burst_left;
   int                   points_sent;
   int                   idle_cycles = 0;
   bit                   hold_request;

   minimax_path_bottleneck u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bottleneck_sq (rsp_bottleneck_sq),
      .rsp_status        (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Keep the low coordinate bits of an integer.
   function automatic logic [IN_COORD_W-1:0] coord_of(input int v);
      return v[IN_COORD_W-1:0];
   endfunction

   // One point transaction. Payload is set at a rising edge and held until the edge at
   // which req_stall (sampled pre-edge) is low. Bursts of random length, then a random
   // gap with valid low; gap 0 keeps valid up so back-to-back streams happen too.
   task automatic send_point(input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                             input logic last);
      int gap;
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_last    <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bottleneck_check.note_point(x, y, last);
      points_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A whole point set, last flag on the final transaction.
   task automatic send_set(input int n, input spread_type spread);
      int                    bx, by, k;
      logic [IN_COORD_W-1:0] x, y;
      bx = $urandom_range(0, 1023);
      by = $urandom_range(0, 1023);
      for (k = 0; k < n; k++) begin
         case (spread)
            SPREAD_FULL: begin
               x = coord_of($urandom_range(0, 1023));
               y = coord_of($urandom_range(0, 1023));
            end
            SPREAD_CLUSTER: begin
               // tight cloud around a random center, wraps at the field edge
               x = coord_of(bx + $urandom_range(0, 63));
               y = coord_of(by + $urandom_range(0, 63));
            end
            default: begin
               // corners only: many duplicates and the largest distances
               x = ($urandom_range(0, 1) == 0) ? '0 : '1;
               y = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
         endcase
         send_point(x, y, k == n - 1);
      end
   endtask

   // Answer side: stall pattern in segments of random mode and length; a single long
   // hold-off when asked, so the block backs up into its input.
   initial begin : answer_side
      rx_mode_type mode;
      int          span, phase;
      bit          hold_done;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done  = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 200);
         for (phase = 0; phase < span; phase++) begin
            case (mode)
               RX_OPEN:     rsp_stall <= 1'b0;
               RX_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 2);
               RX_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 8);
               RX_PERIODIC: rsp_stall <= ((phase % 8) < 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // Answer monitor: a transaction is taken at an edge with valid high and stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         bottleneck_check.check_answer(rsp_bottleneck_sq, rsp_status);
   end

   // Watchdog on cycles with no transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int  n;
      bit  overflow_done, full_done;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_x_coord  = '0;
      req_y_coord  = '0;
      req_last     = 1'b0;
      hold_request = 1'b0;
      points_sent  = 0;
      burst_left   = $urandom_range(1, 40);
      bottleneck_check = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone point (short status), both diagonals at full span,
      // coincident points, a detour cheaper than the direct hop, ties, bit toggles.
      send_point(10'd0,    10'd0,    1'b1);
      send_point(10'd1023, 10'd1023, 1'b1);
      send_point(10'd0,    10'd0,    1'b0);
      send_point(10'd1023, 10'd1023, 1'b1);
      send_point(10'd1023, 10'd0,    1'b0);
      send_point(10'd0,    10'd1023, 1'b1);
      send_point(10'd512,  10'd512,  1'b0);
      send_point(10'd512,  10'd512,  1'b1);
      send_point(10'd0,    10'd0,    1'b0);
      send_point(10'd1000, 10'd0,    1'b0);
      send_point(10'd500,  10'd1,    1'b1);
      send_point(10'd0,    10'd0,    1'b0);
      send_point(10'd10,   10'd0,    1'b0);
      send_point(10'd5,    10'd0,    1'b0);
      send_point(10'd5,    10'd0,    1'b1);
      send_point(10'h155,  10'h2AA,  1'b0);
      send_point(10'h2AA,  10'h155,  1'b1);

      // Random sets, mostly small. One set overruns the store, one fills it exactly.
      hold_request  = 1'b1;
      overflow_done = 1'b0;
      full_done     = 1'b0;
      while (points_sent < TARGET_ITEMS) begin
         if (!overflow_done && points_sent > 600) begin
            n             = STORE_DEPTH + $urandom_range(1, 3);
            overflow_done = 1'b1;
         end else if (!full_done && points_sent > 1300) begin
            n         = STORE_DEPTH;
            full_done = 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            n = 1;
         end else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(13, 40);
         end else begin
            n = $urandom_range(2, 12);
         end
         send_set(n, spread_type'($urandom_range(0, 2)));
      end
      req_valid <= 1'b0;

      // Every set ends in a last point, so each one owes exactly one answer.
      while (bottleneck_check.pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bottleneck_check.failures == 0 && bottleneck_check.pending_answers.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
